>>> design/idll_pkg.sv
// Shared types and constants for the indexed doubly linked list.
package idll_pkg;

	localparam int unsigned IDLL_CAPACITY = 256;

	typedef enum logic [2:0] {
		REQ_APPEND      = 3'd0,
		REQ_INSERT      = 3'd1,
		REQ_REMOVE      = 3'd2,
		REQ_REMOVE_LAST = 3'd3,
		REQ_READ        = 3'd4,
		REQ_CLEAR       = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_ALLOC,
		S_ALLOC_POP,
		S_APP_W1,
		S_APP_W2,
		S_INS_W1,
		S_INS_W2,
		S_RM_W1,
		S_RM_W2,
		S_DONE
	} state_t;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_WALK_HEAD,
		DP_WALK_TAIL,
		DP_WALK_LAST,
		DP_STEP,
		DP_FOUND,
		DP_ALLOC_FREE,
		DP_ALLOC_POP,
		DP_ALLOC_HWM,
		DP_APP_W1,
		DP_APP_W2,
		DP_INS_W1,
		DP_INS_W2,
		DP_RM_W1,
		DP_RM_W2,
		DP_CLEAR,
		DP_FAIL,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t fail_st;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       full;
		logic       empty;
		logic       pos_ge;
		logic       from_head;
		logic       steps_zero;
		logic       free_valid;
		logic       out_busy;
	} dp_stat_t;

endpackage

>>> design/idll_ctrl.sv
// Controller state machine sequencing each request through the datapath.
module idll_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  idll_pkg::dp_stat_t stat,
	output idll_pkg::dp_cmd_t  cmd
);

	idll_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idll_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idll_pkg::S_IDLE: begin
				if (in_valid) state_d = idll_pkg::S_DECODE;
			end
			idll_pkg::S_DECODE: begin
				unique case (stat.req)
					idll_pkg::REQ_APPEND:
						state_d = stat.full ? idll_pkg::S_DONE : idll_pkg::S_ALLOC;
					idll_pkg::REQ_INSERT:
						state_d = (stat.pos_ge || stat.full) ? idll_pkg::S_DONE
							: idll_pkg::S_WALK;
					idll_pkg::REQ_REMOVE, idll_pkg::REQ_READ:
						state_d = (stat.empty || stat.pos_ge) ? idll_pkg::S_DONE
							: idll_pkg::S_WALK;
					idll_pkg::REQ_REMOVE_LAST:
						state_d = stat.empty ? idll_pkg::S_DONE : idll_pkg::S_WALK;
					default: state_d = idll_pkg::S_DONE;
				endcase
			end
			idll_pkg::S_WALK: begin
				if (stat.steps_zero) begin
					priority case (stat.req)
						idll_pkg::REQ_INSERT: state_d = idll_pkg::S_ALLOC;
						idll_pkg::REQ_READ:   state_d = idll_pkg::S_DONE;
						default:              state_d = idll_pkg::S_RM_W1;
					endcase
				end
			end
			idll_pkg::S_ALLOC: begin
				if (stat.free_valid) begin
					state_d = idll_pkg::S_ALLOC_POP;
				end else if (stat.req == idll_pkg::REQ_APPEND) begin
					state_d = idll_pkg::S_APP_W1;
				end else begin
					state_d = idll_pkg::S_INS_W1;
				end
			end
			idll_pkg::S_ALLOC_POP: begin
				state_d = (stat.req == idll_pkg::REQ_APPEND) ? idll_pkg::S_APP_W1
					: idll_pkg::S_INS_W1;
			end
			idll_pkg::S_APP_W1: state_d = idll_pkg::S_APP_W2;
			idll_pkg::S_APP_W2: state_d = idll_pkg::S_DONE;
			idll_pkg::S_INS_W1: state_d = idll_pkg::S_INS_W2;
			idll_pkg::S_INS_W2: state_d = idll_pkg::S_DONE;
			idll_pkg::S_RM_W1:  state_d = idll_pkg::S_RM_W2;
			idll_pkg::S_RM_W2:  state_d = idll_pkg::S_DONE;
			idll_pkg::S_DONE: begin
				if (!stat.out_busy) state_d = idll_pkg::S_IDLE;
			end
			default: state_d = idll_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.op      = idll_pkg::DP_NONE;
		cmd.fail_st = idll_pkg::ST_OK;
		unique case (state_q)
			idll_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = idll_pkg::DP_LOAD;
			end
			idll_pkg::S_DECODE: begin
				unique case (stat.req)
					idll_pkg::REQ_APPEND: begin
						if (stat.full) begin
							cmd.op      = idll_pkg::DP_FAIL;
							cmd.fail_st = idll_pkg::ST_FULL;
						end
					end
					idll_pkg::REQ_INSERT: begin
						if (stat.pos_ge) begin
							cmd.op      = idll_pkg::DP_FAIL;
							cmd.fail_st = idll_pkg::ST_RANGE;
						end else if (stat.full) begin
							cmd.op      = idll_pkg::DP_FAIL;
							cmd.fail_st = idll_pkg::ST_FULL;
						end else begin
							cmd.op = stat.from_head ? idll_pkg::DP_WALK_HEAD
								: idll_pkg::DP_WALK_TAIL;
						end
					end
					idll_pkg::REQ_REMOVE, idll_pkg::REQ_READ: begin
						if (stat.empty) begin
							cmd.op      = idll_pkg::DP_FAIL;
							cmd.fail_st = idll_pkg::ST_EMPTY;
						end else if (stat.pos_ge) begin
							cmd.op      = idll_pkg::DP_FAIL;
							cmd.fail_st = idll_pkg::ST_RANGE;
						end else begin
							cmd.op = stat.from_head ? idll_pkg::DP_WALK_HEAD
								: idll_pkg::DP_WALK_TAIL;
						end
					end
					idll_pkg::REQ_REMOVE_LAST: begin
						if (stat.empty) begin
							cmd.op      = idll_pkg::DP_FAIL;
							cmd.fail_st = idll_pkg::ST_EMPTY;
						end else begin
							cmd.op = idll_pkg::DP_WALK_LAST;
						end
					end
					idll_pkg::REQ_CLEAR: cmd.op = idll_pkg::DP_CLEAR;
					default: cmd.op = idll_pkg::DP_NONE;
				endcase
			end
			idll_pkg::S_WALK:
				cmd.op = stat.steps_zero ? idll_pkg::DP_FOUND : idll_pkg::DP_STEP;
			idll_pkg::S_ALLOC:
				cmd.op = stat.free_valid ? idll_pkg::DP_ALLOC_FREE : idll_pkg::DP_ALLOC_HWM;
			idll_pkg::S_ALLOC_POP: cmd.op = idll_pkg::DP_ALLOC_POP;
			idll_pkg::S_APP_W1:    cmd.op = idll_pkg::DP_APP_W1;
			idll_pkg::S_APP_W2:    cmd.op = idll_pkg::DP_APP_W2;
			idll_pkg::S_INS_W1:    cmd.op = idll_pkg::DP_INS_W1;
			idll_pkg::S_INS_W2:    cmd.op = idll_pkg::DP_INS_W2;
			idll_pkg::S_RM_W1:     cmd.op = idll_pkg::DP_RM_W1;
			idll_pkg::S_RM_W2:     cmd.op = idll_pkg::DP_RM_W2;
			idll_pkg::S_DONE: begin
				if (!stat.out_busy) cmd.op = idll_pkg::DP_OUT;
			end
			default: cmd.op = idll_pkg::DP_NONE;
		endcase
	end

endmodule

>>> design/idll_datapath.sv
// Datapath: node memories, list pointers, walk counter and result register.
module idll_datapath #(
	parameter int unsigned CAPACITY = idll_pkg::IDLL_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  idll_pkg::dp_cmd_t  cmd,
	output idll_pkg::dp_stat_t stat,
	input  logic [2:0]         in_req,
	input  logic [7:0]         in_pos,
	input  logic [31:0]        in_val,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_res,
	output logic [8:0]         out_cnt,
	output logic [1:0]         out_st
);

	localparam int LW   = $clog2(CAPACITY + 1);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CMPW = (LW > 8) ? LW : 8;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	logic [31:0]   val_mem  [CAPACITY];
	logic [LW-1:0] next_mem [CAPACITY];
	logic [LW-1:0] prev_mem [CAPACITY];

	logic [31:0]   val_rd_q;
	logic [LW-1:0] nxt_rd_q, prv_rd_q;

	logic [LW-1:0] head_q, tail_q, free_q, hwm_q, count_q;
	logic [LW-1:0] cur_q, new_q, p_q, x_q, steps_q;
	logic          dir_q;
	logic [2:0]    req_q;
	logic [7:0]    pos_q;
	logic [31:0]   val_q, res_q;
	idll_pkg::status_t st_q;
	logic          out_valid_q;
	logic [31:0]   out_res_q;
	logic [8:0]    out_cnt_q;
	logic [1:0]    out_st_q;

	logic [LW-1:0]   rd_link;
	logic [CMPW-1:0] pos_x, cnt_x;
	logic            vl_we, nx_we, pv_we;
	logic [LW-1:0]   vl_wa, nx_wa, pv_wa, nx_wd, pv_wd;

	assign pos_x = CMPW'(pos_q);
	assign cnt_x = CMPW'(count_q);

	always_comb begin
		stat.req        = req_q;
		stat.full       = (count_q == NIL);
		stat.empty      = (count_q == '0);
		stat.pos_ge     = (pos_x >= cnt_x);
		stat.from_head  = (pos_x <= (cnt_x >> 1));
		stat.steps_zero = (steps_q == '0);
		stat.free_valid = (free_q != NIL);
		stat.out_busy   = out_valid_q && !out_ready;
	end

	always_comb begin
		unique case (cmd.op)
			idll_pkg::DP_WALK_HEAD:  rd_link = head_q;
			idll_pkg::DP_WALK_TAIL,
			idll_pkg::DP_WALK_LAST:  rd_link = tail_q;
			idll_pkg::DP_STEP:       rd_link = dir_q ? nxt_rd_q : prv_rd_q;
			idll_pkg::DP_ALLOC_FREE: rd_link = free_q;
			default:                 rd_link = cur_q;
		endcase
	end

	always_comb begin
		vl_we = 1'b0;
		nx_we = 1'b0;
		pv_we = 1'b0;
		vl_wa = new_q;
		nx_wa = new_q;
		pv_wa = new_q;
		nx_wd = NIL;
		pv_wd = tail_q;
		unique case (cmd.op)
			idll_pkg::DP_APP_W1: begin
				vl_we = 1'b1;
				nx_we = 1'b1;
				pv_we = 1'b1;
			end
			idll_pkg::DP_APP_W2: begin
				nx_we = (tail_q != NIL);
				nx_wa = tail_q;
				nx_wd = new_q;
			end
			idll_pkg::DP_INS_W1: begin
				vl_we = 1'b1;
				nx_we = 1'b1;
				nx_wd = cur_q;
				pv_we = 1'b1;
				pv_wd = p_q;
			end
			idll_pkg::DP_INS_W2: begin
				pv_we = 1'b1;
				pv_wa = cur_q;
				pv_wd = new_q;
				nx_we = (p_q != NIL);
				nx_wa = p_q;
				nx_wd = new_q;
			end
			idll_pkg::DP_RM_W1: begin
				nx_we = (p_q != NIL);
				nx_wa = p_q;
				nx_wd = x_q;
				pv_we = (x_q != NIL);
				pv_wa = x_q;
				pv_wd = p_q;
			end
			idll_pkg::DP_RM_W2: begin
				nx_we = 1'b1;
				nx_wa = cur_q;
				nx_wd = free_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vl_we) val_mem[vl_wa[AW-1:0]] <= val_q;
		if (nx_we) next_mem[nx_wa[AW-1:0]] <= nx_wd;
		if (pv_we) prev_mem[pv_wa[AW-1:0]] <= pv_wd;
		val_rd_q <= val_mem[rd_link[AW-1:0]];
		nxt_rd_q <= next_mem[rd_link[AW-1:0]];
		prv_rd_q <= prev_mem[rd_link[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NIL;
			tail_q      <= NIL;
			free_q      <= NIL;
			hwm_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == idll_pkg::DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				idll_pkg::DP_ALLOC_POP: free_q <= nxt_rd_q;
				idll_pkg::DP_ALLOC_HWM: hwm_q <= hwm_q + LW'(1);
				idll_pkg::DP_APP_W2: begin
					if (tail_q == NIL) head_q <= new_q;
					tail_q  <= new_q;
					count_q <= count_q + LW'(1);
				end
				idll_pkg::DP_INS_W2: begin
					if (p_q == NIL) head_q <= new_q;
					count_q <= count_q + LW'(1);
				end
				idll_pkg::DP_RM_W1: begin
					if (p_q == NIL) head_q <= x_q;
					if (x_q == NIL) tail_q <= p_q;
				end
				idll_pkg::DP_RM_W2: begin
					free_q  <= cur_q;
					count_q <= count_q - LW'(1);
				end
				idll_pkg::DP_CLEAR: begin
					head_q  <= NIL;
					tail_q  <= NIL;
					free_q  <= NIL;
					hwm_q   <= '0;
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			idll_pkg::DP_LOAD: begin
				req_q <= in_req;
				pos_q <= in_pos;
				val_q <= in_val;
				res_q <= '0;
				st_q  <= idll_pkg::ST_OK;
			end
			idll_pkg::DP_WALK_HEAD: begin
				cur_q   <= head_q;
				steps_q <= LW'(pos_x);
				dir_q   <= 1'b1;
			end
			idll_pkg::DP_WALK_TAIL: begin
				cur_q   <= tail_q;
				steps_q <= LW'(cnt_x - CMPW'(1) - pos_x);
				dir_q   <= 1'b0;
			end
			idll_pkg::DP_WALK_LAST: begin
				cur_q   <= tail_q;
				steps_q <= '0;
				dir_q   <= 1'b0;
			end
			idll_pkg::DP_STEP: begin
				cur_q   <= rd_link;
				steps_q <= steps_q - LW'(1);
			end
			idll_pkg::DP_FOUND: begin
				p_q   <= prv_rd_q;
				x_q   <= nxt_rd_q;
				res_q <= val_rd_q;
			end
			idll_pkg::DP_ALLOC_FREE: new_q <= free_q;
			idll_pkg::DP_ALLOC_HWM:  new_q <= hwm_q;
			idll_pkg::DP_APP_W2:     res_q <= 32'(count_q + LW'(1));
			idll_pkg::DP_INS_W2:     res_q <= val_q;
			idll_pkg::DP_CLEAR:      res_q <= 32'(count_q);
			idll_pkg::DP_FAIL:       st_q  <= cmd.fail_st;
			idll_pkg::DP_OUT: begin
				out_res_q <= res_q;
				out_cnt_q <= 9'(count_q);
				out_st_q  <= st_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign out_cnt   = out_cnt_q;
	assign out_st    = out_st_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL && hwm_q <= NIL)
		else $error("entry count or high-water mark beyond the pool size");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == idll_pkg::DP_LOAD |-> ((count_q == '0) == (head_q == NIL)))
		else $error("head pointer disagrees with entry count between requests");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == idll_pkg::DP_LOAD |-> ((count_q == '0) == (tail_q == NIL)))
		else $error("tail pointer disagrees with entry count between requests");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == idll_pkg::DP_OUT |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result is still pending");

endmodule

>>> design/indexed_doubly_linked_list.sv
// Indexed doubly linked list over a fixed node pool, one request per transfer.
// Read, remove and insert walk to the node one node per cycle from the nearer end; append
// and insert take a freed node when one is held, else a fresh one from the high-water mark.
// One request is in flight at a time and an untaken result holds the next request back.
// Reset clears the list, pointers and output; node memories are not cleared, since unused
// nodes are handed out from a high-water mark.
module indexed_doubly_linked_list #(
	parameter int unsigned CAPACITY = idll_pkg::IDLL_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position [7:0], item_value [39:8]
	input  logic [2:0]  s_axis_tuser,  // req_type [2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // result_value [31:0], entry_count [40:32], zeros
	output logic [1:0]  m_axis_tuser   // status [1:0]
);

	idll_pkg::dp_cmd_t  cmd;
	idll_pkg::dp_stat_t stat;
	logic [31:0] out_res;
	logic [8:0]  out_cnt;

	idll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	idll_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_req    (s_axis_tuser),
		.in_pos    (s_axis_tdata[7:0]),
		.in_val    (s_axis_tdata[39:8]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_cnt   (out_cnt),
		.out_st    (m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, out_cnt, out_res};

endmodule

>>> tb/sv/indexed_doubly_linked_list_tb.sv
// Testbench for the indexed doubly linked list: scoreboard over a queue model of the list.
module indexed_doubly_linked_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL = int'(idll_pkg::IDLL_CAPACITY);
	localparam int CYCLE_LIMIT = 900000;
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]  req;
		logic [7:0]  pos;
		logic [31:0] val;
	} request_t;

	typedef struct packed {
		logic [31:0] value;
		logic [8:0]  count;
		logic [1:0]  st;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	request_t    pending_reqs[$];
	answer_t     expected_answers[$];
	logic [31:0] list_contents[$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          quiet_phase = 1'b0;
	int          send_gap = 0;
	int          take_gap = 0;

	indexed_doubly_linked_list u_top (.*);

	always #4 clk = ~clk;

	function automatic answer_t apply_request(request_t r);
		answer_t a;
		int n;
		a = '0;
		n = list_contents.size();
		case (r.req)
			idll_pkg::REQ_APPEND: begin
				if (n >= POOL) begin
					a.st = idll_pkg::ST_FULL;
				end else begin
					list_contents.push_back(r.val);
					a.value = 32'(n + 1);
				end
			end
			idll_pkg::REQ_INSERT: begin
				if (r.pos >= n) begin
					a.st = idll_pkg::ST_RANGE;
				end else if (n >= POOL) begin
					a.st = idll_pkg::ST_FULL;
				end else begin
					list_contents.insert(r.pos, r.val);
					a.value = r.val;
				end
			end
			idll_pkg::REQ_REMOVE, idll_pkg::REQ_READ: begin
				if (n == 0) begin
					a.st = idll_pkg::ST_EMPTY;
				end else if (r.pos >= n) begin
					a.st = idll_pkg::ST_RANGE;
				end else begin
					a.value = list_contents[r.pos];
					if (r.req == idll_pkg::REQ_REMOVE)
						list_contents.delete(r.pos);
				end
			end
			idll_pkg::REQ_REMOVE_LAST: begin
				if (n == 0) begin
					a.st = idll_pkg::ST_EMPTY;
				end else begin
					a.value = list_contents.pop_back();
				end
			end
			idll_pkg::REQ_CLEAR: begin
				a.value = 32'(n);
				list_contents.delete();
			end
			default: ;
		endcase
		a.count = 9'(list_contents.size());
		return a;
	endfunction

	task automatic queue_req(logic [2:0] req, logic [7:0] pos, logic [31:0] val);
		request_t r;
		r.req = req;
		r.pos = pos;
		r.val = val;
		pending_reqs.push_back(r);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_answers.push_back(apply_request({s_axis_tuser, s_axis_tdata[7:0],
					s_axis_tdata[39:8]}));
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0
						&& (quiet_phase || $urandom_range(5) != 0)) begin
					request_t r;
					r = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= r.req;
					s_axis_tdata <= {r.val, r.pos};
				end else begin
					s_axis_tvalid <= 1'b0;
					if (!quiet_phase)
						send_gap <= $urandom_range(2);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				answer_t got;
				answer_t want;
				got = {m_axis_tdata[31:0], m_axis_tdata[40:32], m_axis_tuser};
				if (expected_answers.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					error_count++;
				end else begin
					want = expected_answers.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: result_value expected %h actual %h", $time,
							want.value, got.value);
						error_count++;
					end
					if (got.count !== want.count) begin
						$display("%0t: entry_count expected %0d actual %0d", $time,
							want.count, got.count);
						error_count++;
					end
					if (got.st !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.st, got.st);
						error_count++;
					end
				end
			end
			if (quiet_phase) begin
				m_axis_tready <= 1'b1;
			end else if (take_gap > 0) begin
				take_gap <= take_gap - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(4) == 0) begin
				take_gap <= $urandom_range(2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("indexed_doubly_linked_list_tb: errors");
			$finish;
		end
	end

	initial begin
		int depth;
		int k;
		int choice;
		logic [2:0] req;
		logic [7:0] pos;

		queue_req(idll_pkg::REQ_REMOVE_LAST, 8'd0, 32'd0);
		queue_req(idll_pkg::REQ_REMOVE, 8'd0, 32'd0);
		queue_req(idll_pkg::REQ_READ, 8'd255, 32'd0);
		queue_req(idll_pkg::REQ_INSERT, 8'd0, 32'h1234_5678);
		queue_req(idll_pkg::REQ_CLEAR, 8'd0, 32'd0);
		queue_req(idll_pkg::REQ_APPEND, 8'd0, 32'h8000_0000);
		queue_req(idll_pkg::REQ_REMOVE_LAST, 8'd0, 32'd0);
		queue_req(idll_pkg::REQ_APPEND, 8'd0, 32'h7FFF_FFFF);
		queue_req(idll_pkg::REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
		queue_req(idll_pkg::REQ_INSERT, 8'd0, 32'h0000_0000);
		queue_req(idll_pkg::REQ_INSERT, 8'd2, 32'hA5A5_5A5A);
		queue_req(idll_pkg::REQ_INSERT, 8'd4, 32'd1);
		queue_req(idll_pkg::REQ_READ, 8'd3, 32'd0);
		queue_req(idll_pkg::REQ_READ, 8'd4, 32'd0);
		queue_req(idll_pkg::REQ_REMOVE, 8'd1, 32'd0);
		queue_req(idll_pkg::REQ_REMOVE, 8'd9, 32'd0);
		queue_req(REQ_SPARE_A, 8'hFF, 32'hFFFF_FFFF);
		queue_req(REQ_SPARE_B, 8'h00, 32'h0);
		queue_req(idll_pkg::REQ_CLEAR, 8'd0, 32'd0);
		queue_req(idll_pkg::REQ_CLEAR, 8'd0, 32'd0);

		// Fill the pool to the brim, probe full and far positions, then remove at random positions up to 180 and clear.
		for (k = 0; k < POOL; k++)
			queue_req(idll_pkg::REQ_APPEND, 8'd0, $urandom());
		queue_req(idll_pkg::REQ_APPEND, 8'd0, 32'd5);
		queue_req(idll_pkg::REQ_INSERT, 8'd128, 32'd5);
		queue_req(idll_pkg::REQ_READ, 8'd255, 32'd0);
		queue_req(idll_pkg::REQ_READ, 8'd127, 32'd0);
		queue_req(idll_pkg::REQ_READ, 8'd128, 32'd0);
		for (k = 0; k < 60; k++)
			queue_req(idll_pkg::REQ_REMOVE, 8'($urandom_range(180)), 32'd0);
		queue_req(idll_pkg::REQ_CLEAR, 8'd0, 32'd0);

		// Random part, biased towards long lists so that walks go deep.
		depth = 0;
		for (k = 0; k < 860; k++) begin
			choice = $urandom_range(99);
			pos = 8'((depth > 0 && $urandom_range(9) != 0) ? $urandom_range(depth - 1)
				: $urandom());
			if (choice < 38) req = idll_pkg::REQ_APPEND;
			else if (choice < 58) req = idll_pkg::REQ_INSERT;
			else if (choice < 70) req = idll_pkg::REQ_REMOVE;
			else if (choice < 77) req = idll_pkg::REQ_REMOVE_LAST;
			else if (choice < 97) req = idll_pkg::REQ_READ;
			else if (choice < 99) req = idll_pkg::REQ_CLEAR;
			else req = ($urandom_range(1) != 0) ? REQ_SPARE_B : REQ_SPARE_A;
			case (req)
				idll_pkg::REQ_APPEND: if (depth < POOL) depth++;
				idll_pkg::REQ_INSERT: if (pos < depth && depth < POOL) depth++;
				idll_pkg::REQ_REMOVE: if (pos < depth) depth--;
				idll_pkg::REQ_REMOVE_LAST: if (depth > 0) depth--;
				idll_pkg::REQ_CLEAR: depth = 0;
				default: ;
			endcase
			queue_req(req, pos, $urandom());
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 100)
			@(posedge clk);
		quiet_phase = 1'b1;
		while (pending_reqs.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_answers.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0) begin
			$display("indexed_doubly_linked_list_tb: clean");
		end else begin
			$display("indexed_doubly_linked_list_tb: errors");
		end
		$finish;
	end

endmodule
